/* design/tvsl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the three-axis variable-step low-pass filter.
// No dependencies; every other design file refers to it by scoped names.
package tvsl_pkg;

  localparam int AXIS_COUNT   = 3;
  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 16;
  localparam int FV_W         = SAMPLE_WIDTH + FRAC_BITS;
  localparam int TAU_W        = 24;
  localparam int STEP_W       = 20;
  localparam int ALPHA_W      = FRAC_BITS;
  localparam int DEN_W        = TAU_W + 1;
  localparam int STATUS_W     = 2;
  localparam int IN_DATA_W    = ((AXIS_COUNT * SAMPLE_WIDTH + STEP_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((AXIS_COUNT * SAMPLE_WIDTH + 7) / 8) * 8;

  localparam logic [TAU_W-1:0] TAU_MIN_VALID = TAU_W'(319);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_TAU    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_STEP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_e;

  // Command broadcast from the sequencer to every axis lane.
  typedef struct packed {
    logic clear;
    logic seed;
    logic mult;
    logic accum;
  } lane_cmd_t;

endpackage

/* design/tvsl_alpha_div.sv */
`timescale 1ns / 1ps
// Restoring divider for alpha = floor(step * 2^16 / (tau + step)), one bit a cycle.
// Depends on tvsl_pkg.
module tvsl_alpha_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tvsl_pkg::STEP_W-1:0]   step_i,
  input  logic [tvsl_pkg::TAU_W-1:0]    tau_i,
  output logic                          done_o,
  output logic [tvsl_pkg::ALPHA_W-1:0]  alpha_o
);

  localparam int CNT_W = $clog2(tvsl_pkg::ALPHA_W + 1);

  logic                          busy_q, busy_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [tvsl_pkg::DEN_W-1:0]    den_q, den_d;
  logic [tvsl_pkg::DEN_W-1:0]    rem_q, rem_d;
  logic [tvsl_pkg::ALPHA_W-1:0]  quo_q, quo_d;
  logic [tvsl_pkg::DEN_W:0]      rem_sh;
  logic                          fits;

  assign rem_sh = {rem_q, 1'b0};
  assign fits   = rem_sh >= {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == '0);
  assign alpha_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(tvsl_pkg::ALPHA_W);
      den_d  = tvsl_pkg::DEN_W'(tau_i) + tvsl_pkg::DEN_W'(step_i);
      // step < tau + step, so the remainder starts as step itself
      rem_d  = tvsl_pkg::DEN_W'(step_i);
      quo_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        quo_d = {quo_q[tvsl_pkg::ALPHA_W-2:0], fits};
        rem_d = fits ? tvsl_pkg::DEN_W'(rem_sh - {1'b0, den_q})
                     : rem_sh[tvsl_pkg::DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

endmodule

/* design/tvsl_lane.sv */
`timescale 1ns / 1ps
// One axis lane: holds the filtered value and applies seed, clear and update.
// Depends on tvsl_pkg.
module tvsl_lane (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  tvsl_pkg::lane_cmd_t                     cmd_i,
  input  logic [tvsl_pkg::ALPHA_W-1:0]            alpha_i,
  input  logic signed [tvsl_pkg::SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [tvsl_pkg::SAMPLE_WIDTH-1:0] filtered_o
);

  localparam int DIFF_W = tvsl_pkg::FV_W + 1;
  localparam int PROD_W = DIFF_W + tvsl_pkg::ALPHA_W + 1;

  logic signed [tvsl_pkg::FV_W-1:0] fv_q, fv_d;
  logic signed [PROD_W-1:0]         prod_q;
  logic signed [tvsl_pkg::FV_W-1:0] target;
  logic signed [DIFF_W-1:0]         diff;
  logic signed [tvsl_pkg::ALPHA_W:0] alpha_s;
  logic signed [tvsl_pkg::FV_W-1:0] delta;

  assign target  = {sample_i, {tvsl_pkg::FRAC_BITS{1'b0}}};
  assign diff    = DIFF_W'(target) - DIFF_W'(fv_q);
  assign alpha_s = {1'b0, alpha_i};
  // floor(alpha * diff / 2^16), truncated to the state width
  assign delta   = prod_q[tvsl_pkg::FV_W+tvsl_pkg::FRAC_BITS-1:tvsl_pkg::FRAC_BITS];
  assign filtered_o = fv_q[tvsl_pkg::FV_W-1:tvsl_pkg::FRAC_BITS];

  always_comb begin
    fv_d = fv_q;
    if (cmd_i.clear) begin
      fv_d = '0;
    end else if (cmd_i.seed) begin
      fv_d = target;
    end else if (cmd_i.accum) begin
      fv_d = fv_q + delta;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      prod_q <= PROD_W'(alpha_s) * PROD_W'(diff);
    end
  end

endmodule

/* design/three_axis_variable_step_lowpass.sv */
`timescale 1ns / 1ps
// Top level: request sequencer, tau register, axis lanes and result merge.
// Depends on tvsl_pkg, tvsl_alpha_div and tvsl_lane.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  s_axis   | s_axis_tvalid/tready   | tdata x,y,z,step_us; tuser kind
//  m_axis   | m_axis_tvalid/tready   | tdata filtered x,y,z; tuser status
//  cfg      | cfg_valid_i/cfg_ready_o| cfg_data_i time_constant_us
//
// A filtered sample passes through evaluate, divide (16 quotient bits, then a done
// check), multiply, accumulate and emit. With no stall the sequencer returns to idle
// after emit and takes the next request there.
// Seed, clear and rejected requests go from evaluate straight to emit.
// One request is processed at a time. Reset clears tau, the filtered values and seeded.
// A stalled result waits in the output register; the next request is taken meanwhile
// and holds in emit until the register frees.
module three_axis_variable_step_lowpass (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [67:48] step_us, rest zero
  input  logic [tvsl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] kind
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] filtered_x, [31:16] filtered_y, [47:32] filtered_z
  output logic [tvsl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [1:0] status
  output logic [tvsl_pkg::STATUS_W-1:0]       m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [tvsl_pkg::TAU_W-1:0]          cfg_data_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o
);

  localparam int AC = tvsl_pkg::AXIS_COUNT;
  localparam int SW = tvsl_pkg::SAMPLE_WIDTH;

  tvsl_pkg::state_e state_q, state_d;

  logic [tvsl_pkg::TAU_W-1:0]    tau_q;
  logic                          tau_ok_q;
  logic                          seeded_q, seeded_d;
  logic                          kind_q;
  logic [tvsl_pkg::STEP_W-1:0]   step_q;
  logic signed [SW-1:0]          sample_q [AC];
  logic signed [SW-1:0]          lane_out [AC];
  logic [tvsl_pkg::STATUS_W-1:0] status_q, status_d;
  logic [AC*SW-1:0]              out_data_q;
  logic [tvsl_pkg::STATUS_W-1:0] out_status_q;
  logic                          out_valid_q;

  tvsl_pkg::lane_cmd_t           cmd;
  logic                          in_fire;
  logic                          cfg_fire;
  logic                          cfg_tau_ok;
  logic                          div_start;
  logic                          div_done;
  logic [tvsl_pkg::ALPHA_W-1:0]  alpha;
  logic                          emit;
  logic                          out_free;

  assign s_axis_tready = state_q == tvsl_pkg::ST_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign cfg_tau_ok    = cfg_data_i >= tvsl_pkg::TAU_MIN_VALID;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tdata  = tvsl_pkg::OUT_DATA_W'(out_data_q);
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tvalid = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tvsl_pkg::ST_IDLE: begin
        if (in_fire) state_d = tvsl_pkg::ST_EVAL;
      end
      tvsl_pkg::ST_EVAL: begin
        if (tau_ok_q && kind_q == tvsl_pkg::KIND_SAMPLE && seeded_q && step_q != '0) begin
          state_d = tvsl_pkg::ST_DIV;
        end else begin
          state_d = tvsl_pkg::ST_EMIT;
        end
      end
      tvsl_pkg::ST_DIV: begin
        if (div_done) state_d = tvsl_pkg::ST_MUL;
      end
      tvsl_pkg::ST_MUL: state_d = tvsl_pkg::ST_ACC;
      tvsl_pkg::ST_ACC: state_d = tvsl_pkg::ST_EMIT;
      tvsl_pkg::ST_EMIT: begin
        if (out_free) state_d = tvsl_pkg::ST_IDLE;
      end
      default: state_d = tvsl_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    cmd       = '0;
    div_start = 1'b0;
    emit      = 1'b0;
    seeded_d  = seeded_q;
    status_d  = status_q;
    // a valid tau write re-initializes the filter
    if (cfg_fire && cfg_tau_ok) begin
      cmd.clear = 1'b1;
      seeded_d  = 1'b0;
    end
    case (state_q)
      tvsl_pkg::ST_EVAL: begin
        status_d = tvsl_pkg::STATUS_OK;
        if (!tau_ok_q) begin
          status_d = tvsl_pkg::STATUS_NO_TAU;
        end else if (kind_q == tvsl_pkg::KIND_CLEAR) begin
          cmd.clear = 1'b1;
          seeded_d  = 1'b0;
        end else if (!seeded_q) begin
          cmd.seed = 1'b1;
          seeded_d = 1'b1;
        end else if (step_q == '0) begin
          status_d = tvsl_pkg::STATUS_ZERO_STEP;
        end else begin
          div_start = 1'b1;
        end
      end
      tvsl_pkg::ST_MUL:  cmd.mult  = 1'b1;
      tvsl_pkg::ST_ACC:  cmd.accum = 1'b1;
      tvsl_pkg::ST_EMIT: emit      = out_free;
      default: ;
    endcase
  end

  tvsl_alpha_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .step_i  (step_q),
    .tau_i   (tau_q),
    .done_o  (div_done),
    .alpha_o (alpha)
  );

  for (genvar a = 0; a < AC; a++) begin : g_lane
    tvsl_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .alpha_i    (alpha),
      .sample_i   (sample_q[a]),
      .filtered_o (lane_out[a])
    );
  end

  // Capture the samples and merge the lane results into one output word
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < AC; a++) begin
      if (in_fire) sample_q[a] <= s_axis_tdata[a*SW +: SW];
      if (emit) out_data_q[a*SW +: SW] <= lane_out[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tvsl_pkg::ST_IDLE;
      tau_q       <= '0;
      tau_ok_q    <= 1'b0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      seeded_q <= seeded_d;
      if (cfg_fire) begin
        tau_q    <= cfg_data_i;
        tau_ok_q <= cfg_tau_ok;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (in_fire) begin
      kind_q <= s_axis_tuser;
      step_q <= s_axis_tdata[AC*SW +: tvsl_pkg::STEP_W];
    end
    if (emit) out_status_q <= status_q;
  end

  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == tvsl_pkg::ST_EVAL)
    else $error("accepted request did not move to evaluation");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == tvsl_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == tvsl_pkg::ST_EMIT))
    else $error("result appeared without passing through emit");

  a_zero_step_seeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tvsl_pkg::ST_EMIT && status_q == tvsl_pkg::STATUS_ZERO_STEP) |-> seeded_q)
    else $error("zero-step status reported while not seeded");

endmodule

/* verif/three_axis_variable_step_lowpass_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for three_axis_variable_step_lowpass: a directed table, then random phases.
// Depends on tvsl_pkg and the design; a local filter predictor, or a typed row's expectation, checks every result.
module three_axis_variable_step_lowpass_test;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 30;
  localparam int DIR_ROWS     = 25;
  localparam int PHASES       = 7;
  localparam int HOLD_CYCLES  = 400;
  localparam int SW           = tvsl_pkg::SAMPLE_WIDTH;
  localparam int AC           = tvsl_pkg::AXIS_COUNT;

  typedef enum logic {ROW_REQ, ROW_CFG} row_op_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // One stimulus row; typed rows carry an expectation read straight off the spec.
  typedef struct packed {
    row_op_e                          op;
    logic [tvsl_pkg::TAU_W-1:0]       tau;
    logic                             kind;
    logic [SW-1:0]                    ax;
    logic [SW-1:0]                    ay;
    logic [SW-1:0]                    az;
    logic [tvsl_pkg::STEP_W-1:0]      step;
    logic                             typed;
    logic [SW-1:0]                    ex;
    logic [SW-1:0]                    ey;
    logic [SW-1:0]                    ez;
    logic [tvsl_pkg::STATUS_W-1:0]    est;
  } row_t;

  typedef struct packed {
    logic [tvsl_pkg::OUT_DATA_W-1:0] data;
    logic [tvsl_pkg::STATUS_W-1:0]   status;
  } filtered_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic [tvsl_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                            s_axis_tuser  = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [tvsl_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [tvsl_pkg::STATUS_W-1:0]   m_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [tvsl_pkg::TAU_W-1:0]      cfg_data_i    = '0;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;

  // Predictor state
  longint                     filt_state [AC];
  bit                         seeded_state;
  logic [tvsl_pkg::TAU_W-1:0] tau_state;
  filtered_t                  pending_filtered [$];

  int         mismatch_count  = 0;
  int         results_checked = 0;
  int         requests_sent   = 0;
  int         tau_writes      = 0;
  int         hold_requests   = 0;
  int         cycle_count     = 0;
  idle_mode_e idle_mode       = IDLE_NONE;

  three_axis_variable_step_lowpass uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data_i    (cfg_data_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_filtered.size());
      $display("three_axis_variable_step_lowpass regression: fail");
      $finish;
    end
  end

  function automatic void clear_filter();
    for (int a = 0; a < AC; a++) filt_state[a] = 0;
    seeded_state = 1'b0;
  endfunction

  function automatic void load_tau(input logic [tvsl_pkg::TAU_W-1:0] v);
    tau_state = v;
    if (v >= tvsl_pkg::TAU_MIN_VALID) clear_filter();
  endfunction

  function automatic filtered_t predict_filter(input row_t r);
    filtered_t          res;
    logic [AC*SW-1:0]   accel;
    longint             alpha;
    longint             target;
    accel      = {r.az, r.ay, r.ax};
    res.status = tvsl_pkg::STATUS_OK;
    if (tau_state < tvsl_pkg::TAU_MIN_VALID) begin
      res.status = tvsl_pkg::STATUS_NO_TAU;
    end else if (r.kind == tvsl_pkg::KIND_CLEAR) begin
      clear_filter();
    end else if (!seeded_state) begin
      for (int a = 0; a < AC; a++)
        filt_state[a] = longint'($signed(accel[a*SW +: SW])) <<< tvsl_pkg::FRAC_BITS;
      seeded_state = 1'b1;
    end else if (r.step == '0) begin
      res.status = tvsl_pkg::STATUS_ZERO_STEP;
    end else begin
      alpha = (longint'(r.step) <<< tvsl_pkg::FRAC_BITS) /
              (longint'(tau_state) + longint'(r.step));
      for (int a = 0; a < AC; a++) begin
        target = longint'($signed(accel[a*SW +: SW])) <<< tvsl_pkg::FRAC_BITS;
        // floor(alpha * diff / 2^16), arithmetic shift rounds toward minus infinity
        filt_state[a] = filt_state[a] +
                        ((alpha * (target - filt_state[a])) >>> tvsl_pkg::FRAC_BITS);
      end
    end
    res.data = '0;
    for (int a = 0; a < AC; a++)
      res.data[a*SW +: SW] = SW'(filt_state[a] >>> tvsl_pkg::FRAC_BITS);
    return res;
  endfunction

  task automatic send_request(input row_t r);
    filtered_t want;
    s_axis_tdata  <= tvsl_pkg::IN_DATA_W'({r.step, r.az, r.ay, r.ax});
    s_axis_tuser  <= r.kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_filter(r);
    if (r.typed) begin
      want.data   = tvsl_pkg::OUT_DATA_W'({r.ez, r.ey, r.ex});
      want.status = r.est;
    end
    pending_filtered.push_back(want);
    requests_sent++;
  endtask

  task automatic write_tau(input logic [tvsl_pkg::TAU_W-1:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    load_tau(v);
    tau_writes++;
  endtask

  // Hold the input until every expected result is back, then let the pipe settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Drop the request for a cycle at a time, each cycle with the phase's idle odds.
  task automatic idle_sender();
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 46 : (idle_mode == IDLE_BOTH) ? 12 : 0;
    while ($urandom_range(0, 99) < pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic row_t random_request();
    row_t r;
    int   sel;
    r      = '0;
    r.op   = ROW_REQ;
    r.kind = ($urandom_range(0, 99) < 5) ? tvsl_pkg::KIND_CLEAR : tvsl_pkg::KIND_SAMPLE;
    r.ax   = SW'($urandom);
    r.ay   = SW'($urandom);
    r.az   = SW'($urandom);
    sel    = $urandom_range(0, 99);
    if (sel < 10)      r.step = '0;
    else if (sel < 20) r.step = tvsl_pkg::STEP_W'($urandom);
    else if (sel < 25) r.step = '1;
    else if (sel < 85) r.step = tvsl_pkg::STEP_W'($urandom_range(1, 2000));
    else               r.step = tvsl_pkg::STEP_W'($urandom_range(1, 100000));
    return r;
  endfunction

  task automatic check_result();
    filtered_t want;
    if (pending_filtered.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual data %h status %0d",
               $time, m_axis_tdata, m_axis_tuser);
      mismatch_count++;
    end else begin
      want = pending_filtered.pop_front();
      results_checked++;
      for (int a = 0; a < AC; a++) begin
        if (m_axis_tdata[a*SW +: SW] !== want.data[a*SW +: SW]) begin
          $display("%0t: axis %0d expected %0d actual %0d", $time, a,
                   $signed(want.data[a*SW +: SW]),
                   $signed(m_axis_tdata[a*SW +: SW]));
          mismatch_count++;
        end
      end
      if (m_axis_tuser !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
        mismatch_count++;
      end
    end
  endtask

  initial begin : result_monitor
    int holds_taken;
    int hold_left;
    int stall_pct;
    holds_taken = 0;
    hold_left   = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
      if (hold_requests != holds_taken) begin
        holds_taken = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      stall_pct = (idle_mode == IDLE_RECV) ? 46 : (idle_mode == IDLE_BOTH) ? 12 : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin : stimulus
    row_t                       dir_tab [DIR_ROWS];
    idle_mode_e                 phase_mode [PHASES];
    int                         phase_items [PHASES];
    logic [tvsl_pkg::TAU_W-1:0] tau_pick;
    dir_tab = '{
      // unconfigured after reset: state is zero
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h7fff, 16'h8000, 16'h0001, 20'hfffff,
        1'b1, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_NO_TAU},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000, 20'd0,
        1'b1, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_NO_TAU},
      // largest invalid tau
      '{ROW_CFG, 24'd318, tvsl_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 20'd0,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h1234, 16'h5678, 16'h9abc, 20'd0,
        1'b1, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_NO_TAU},
      // smallest valid tau; zero step seeds while unseeded
      '{ROW_CFG, 24'd319, tvsl_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 20'd0,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h7fff, 16'h8000, 16'h0000, 20'd0,
        1'b1, 16'h7fff, 16'h8000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 20'd0,
        1'b1, 16'h7fff, 16'h8000, 16'h0000, tvsl_pkg::STATUS_ZERO_STEP},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h8000, 16'h7fff, 16'hffff, 20'd1,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h8000, 16'h7fff, 16'hffff, 20'hfffff,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_CLEAR, 16'h7fff, 16'h7fff, 16'h7fff, 20'd5,
        1'b1, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'hffff, 16'h0001, 16'h5555, 20'd0,
        1'b1, 16'hffff, 16'h0001, 16'h5555, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'haaaa, 16'h1234, 16'hedcb, 20'd1000,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      // largest tau; the write re-initializes, so the next sample seeds
      '{ROW_CFG, 24'hffffff, tvsl_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 20'd0,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h4000, 16'hc000, 16'h0800, 20'd5,
        1'b1, 16'h4000, 16'hc000, 16'h0800, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 20'hfffff,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h7fff, 16'h7fff, 16'h7fff, 20'd1,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      // invalid tau keeps the state; clears are rejected too
      '{ROW_CFG, 24'd1, tvsl_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 20'd0,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h1111, 16'h2222, 16'h3333, 20'd100,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000, 20'd0,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_CFG, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 20'd0,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h0f0f, 16'hf0f0, 16'h00ff, 20'd77,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_CFG, 24'd2000, tvsl_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 20'd0,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h0100, 16'hff00, 16'h0010, 20'd7,
        1'b1, 16'h0100, 16'hff00, 16'h0010, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h7fff, 16'h8000, 16'h0000, 20'd2000,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK},
      '{ROW_REQ, 24'd0, tvsl_pkg::KIND_SAMPLE, 16'h8000, 16'h7fff, 16'h0000, 20'd20,
        1'b0, 16'h0000, 16'h0000, 16'h0000, tvsl_pkg::STATUS_OK}
    };
    phase_mode  = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_SEND, IDLE_BOTH};
    phase_items = '{80, 80, 80, 80, 80, 20, 80};

    tau_state = '0;
    clear_filter();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].op == ROW_CFG) begin
        drain();
        write_tau(dir_tab[i].tau);
      end else begin
        send_request(dir_tab[i]);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin
          tau_pick = tvsl_pkg::TAU_W'($urandom_range(319, 20000));
        end
        2: begin
          tau_pick = tvsl_pkg::TAU_W'($urandom_range(319, 1000));
        end
        4: begin
          tau_pick = tvsl_pkg::TAU_W'($urandom_range(500, 5000));
        end
        5: begin
          // invalid tau: everything rejected, state kept from the phase before
          tau_pick = tvsl_pkg::TAU_W'($urandom_range(1, 318));
        end
        6: begin
          tau_pick = tvsl_pkg::TAU_W'($urandom_range(2000, 100000));
        end
        default: begin
          tau_pick = tvsl_pkg::TAU_W'($urandom);
          if (tau_pick < tvsl_pkg::TAU_MIN_VALID) tau_pick = tvsl_pkg::TAU_MIN_VALID;
        end
      endcase
      write_tau(tau_pick);
      idle_mode = phase_mode[p];
      for (int i = 0; i < phase_items[p]; i++) begin
        // back-pressure phase: long receiver hold while requests keep coming, then a full pause
        if (p == 4 && i == 10) hold_requests++;
        if (p == 4 && i == 60) drain();
        idle_sender();
        send_request(random_request());
      end
    end

    drain();
    $display("Covered %0d requests and %0d tau writes; %0d results checked", requests_sent,
             tau_writes, results_checked);
    $display("Phases: no idling, sender gaps, receiver stalls, both, long hold, invalid tau");
    if (mismatch_count == 0) begin
      $display("three_axis_variable_step_lowpass regression: pass");
    end else begin
      $display("three_axis_variable_step_lowpass regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
design/tvsl_pkg.sv
design/tvsl_alpha_div.sv
design/tvsl_lane.sv
design/three_axis_variable_step_lowpass.sv
verif/three_axis_variable_step_lowpass_test.sv
